// File: rtl/odwm_pkg.sv
// Shared types, constants and arithmetic helpers of the omni drive wheel mixer.
package odwm_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] LIMIT_RESET = 7'd80;
  localparam logic signed [11:0] LEVEL_MAX = 12'sd100;

  // Q2.14 wheel geometry and Q3.14 spin gain.
  localparam logic signed [25:0] SIN_15_Q14 = 26'sd4240;
  localparam logic signed [25:0] COS_15_Q14 = 26'sd15826;
  localparam logic signed [25:0] SPIN_GAIN_Q14 = 26'sd57648;

  localparam logic [14:0] QUARTER_SINE [91] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // A classified command as it waits between the front and the back.
  typedef struct packed {
    logic signed [7:0]  power;
    logic signed [15:0] sin_q;
    logic signed [15:0] cos_q;
    logic signed [7:0]  spin;
    logic signed [7:0]  kick;
  } odwm_item_t;

  typedef struct packed {
    logic       reverse;
    logic [6:0] level;
  } odwm_chan_t;

  // Sine of d whole degrees, d in 0..359, as signed Q2.14.
  function automatic logic signed [15:0] sine_q14(input logic [8:0] d);
    logic [8:0]         idx;
    logic               neg;
    logic signed [15:0] mag;
    if (d <= 9'd90) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = d - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - d;
      neg = 1'b1;
    end
    mag = 16'(QUARTER_SINE[idx[6:0]]);
    return neg ? -mag : mag;
  endfunction

  // Divide by 2**14, truncating toward zero.
  function automatic logic signed [11:0] trunc_q14(input logic signed [25:0] v);
    logic signed [25:0] b;
    b = v + (v[25] ? 26'sd16383 : 26'sd0);
    return 12'(b >>> 14);
  endfunction

  // Channel value to direction and magnitude; out of range gives forward, zero.
  function automatic odwm_chan_t encode(input logic signed [11:0] v);
    odwm_chan_t c;
    c = '0;
    if (v < 12'sd0 && v >= -LEVEL_MAX) begin
      c.reverse = 1'b1;
      c.level   = 7'(-v);
    end else if (v >= 12'sd0 && v <= LEVEL_MAX) begin
      c.level = 7'(v);
    end
    return c;
  endfunction

endpackage

// File: rtl/odwm_cmd_if.sv
// Drive command channel: valid/ready handshake with the command fields.
interface odwm_cmd_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] power;
  logic [8:0]        heading;
  logic signed [7:0] spin;
  logic signed [7:0] kick;

  modport source (output valid, output power, output heading, output spin,
                  output kick, input ready);
  modport sink (input valid, input power, input heading, input spin,
                input kick, output ready);
endinterface

// File: rtl/odwm_drv_if.sv
// Motor driver channel: valid/ready handshake with four direction/level pairs.
interface odwm_drv_if;
  logic       valid;
  logic       ready;
  logic       ch1_reverse;
  logic [6:0] ch1_level;
  logic       ch2_reverse;
  logic [6:0] ch2_level;
  logic       ch3_reverse;
  logic [6:0] ch3_level;
  logic       ch4_reverse;
  logic [6:0] ch4_level;

  modport source (output valid, output ch1_reverse, output ch1_level,
                  output ch2_reverse, output ch2_level, output ch3_reverse,
                  output ch3_level, output ch4_reverse, output ch4_level,
                  input ready);
  modport sink (input valid, input ch1_reverse, input ch1_level,
                input ch2_reverse, input ch2_level, input ch3_reverse,
                input ch3_level, input ch4_reverse, input ch4_level,
                output ready);
endinterface

// File: rtl/odwm_front.sv
// Front end: accepts commands, clamps power and looks up the heading trig.
module odwm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [6:0]           power_limit,
  odwm_cmd_if.sink             in_word,
  output logic                 item_valid,
  output odwm_pkg::odwm_item_t item,
  input  logic                 item_ready
);

  logic                 valid_r, valid_nxt;
  odwm_pkg::odwm_item_t item_r, item_nxt;
  logic signed [7:0]    lim;
  logic [8:0]           head;
  logic [9:0]           head_c;
  logic [8:0]           head_cos;
  logic                 take;

  assign in_word.ready = !valid_r || item_ready;
  assign take          = in_word.valid && in_word.ready;

  always_comb begin
    lim      = $signed({1'b0, power_limit});
    head     = (in_word.heading >= 9'd360) ? in_word.heading - 9'd360 : in_word.heading;
    head_c   = 10'(head) + 10'd90;
    head_cos = (head_c >= 10'd360) ? 9'(head_c - 10'd360) : head_c[8:0];

    item_nxt.power = in_word.power;
    if (in_word.power > lim) begin
      item_nxt.power = lim;
    end else if (in_word.power < -lim) begin
      item_nxt.power = -lim;
    end
    item_nxt.sin_q = odwm_pkg::sine_q14(head);
    item_nxt.cos_q = odwm_pkg::sine_q14(head_cos);
    item_nxt.spin  = in_word.spin;
    item_nxt.kick  = in_word.kick;

    valid_nxt = take || (valid_r && !item_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/odwm_queue.sv
// Short first-in first-out queue between the front and the back.
module odwm_queue #(
  parameter int unsigned DEPTH = odwm_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  input  odwm_pkg::odwm_item_t wr_item,
  output logic                 wr_ready,
  output logic                 rd_valid,
  output odwm_pkg::odwm_item_t rd_item,
  input  logic                 rd_ready
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  odwm_pkg::odwm_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: rtl/odwm_back.sv
// Back end: resolves power into vx/vy, mixes wheel speeds and encodes channels.
module odwm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  odwm_pkg::odwm_item_t item,
  output logic                 item_ready,
  odwm_drv_if.source           out_word
);

  // The whole pipeline moves together unless the output register is held.
  logic en;

  // Stage one: power times sine and cosine.
  logic               v1_r, v1_nxt;
  logic signed [23:0] px_r, py_r;
  logic signed [7:0]  spin1_r, kick1_r;

  // Stage two: truncated vx, vy and the mixing products.
  logic               v2_r, v2_nxt;
  logic signed [11:0] vx, vy;
  logic signed [11:0] vx2_r;
  logic signed [25:0] a2_r, b2_r, g2_r;
  logic signed [7:0]  kick2_r;

  // Stage three: output register.
  logic               ov_r, ov_nxt;
  logic signed [25:0] sum_r, sum_b, sum_l;
  logic signed [11:0] m_r, m_b, m_l;
  odwm_pkg::odwm_chan_t c1_r, c2_r, c3_r, c4_r;
  odwm_pkg::odwm_chan_t c1_nxt, c2_nxt, c3_nxt, c4_nxt;

  assign en         = !ov_r || out_word.ready;
  assign item_ready = en;

  always_comb begin
    v1_nxt = en ? item_valid : v1_r;
    v2_nxt = en ? v1_r : v2_r;
    ov_nxt = en ? v2_r : ov_r;

    vx = odwm_pkg::trunc_q14(26'(px_r));
    vy = odwm_pkg::trunc_q14(26'(py_r));

    sum_r = a2_r - b2_r - g2_r;
    sum_b = (26'(vx2_r) <<< 14) + g2_r;
    sum_l = -a2_r - b2_r + g2_r;
    m_r   = odwm_pkg::trunc_q14(sum_r);
    m_b   = odwm_pkg::trunc_q14(sum_b);
    m_l   = odwm_pkg::trunc_q14(sum_l);

    c1_nxt = odwm_pkg::encode(-m_r);
    c2_nxt = odwm_pkg::encode(-m_b);
    c3_nxt = odwm_pkg::encode(m_l);
    c4_nxt = odwm_pkg::encode(12'(kick2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= 24'(item.power) * 24'(item.cos_q);
      py_r    <= 24'(item.power) * 24'(item.sin_q);
      spin1_r <= item.spin;
      kick1_r <= item.kick;

      vx2_r   <= vx;
      a2_r    <= 26'(vx) * odwm_pkg::SIN_15_Q14;
      b2_r    <= 26'(vy) * odwm_pkg::COS_15_Q14;
      g2_r    <= 26'(spin1_r) * odwm_pkg::SPIN_GAIN_Q14;
      kick2_r <= kick1_r;

      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      c3_r <= c3_nxt;
      c4_r <= c4_nxt;
    end
  end

  assign out_word.valid       = ov_r;
  assign out_word.ch1_reverse = c1_r.reverse;
  assign out_word.ch1_level   = c1_r.level;
  assign out_word.ch2_reverse = c2_r.reverse;
  assign out_word.ch2_level   = c2_r.level;
  assign out_word.ch3_reverse = c3_r.reverse;
  assign out_word.ch3_level   = c3_r.level;
  assign out_word.ch4_reverse = c4_r.reverse;
  assign out_word.ch4_level   = c4_r.level;

endmodule

// File: rtl/omni_drive_wheel_mixer_unit.sv
// Top level of the omni drive wheel mixer: front end, queue and back end.
//
// A drive command word (power, heading, spin, kick) enters on in_word and is
// taken at a rising edge where valid and ready are both high. Each command
// gives exactly one result word on out_word: direction and level for four
// motor-driver channels. Channels one and two carry the negated right and back
// wheel speeds, channel three the left wheel speed, channel four the kick.
// The power clamp limit is written through cfg_we/cfg_wdata while idle.
//
// Throughput is one word per cycle while the receiver holds out_word.ready high.
// A command passes through the front register, the queue, and two multiply
// stages in the back before the output register.
//
// Reset (rst_n low, synchronous) empties the pipeline and the queue and sets
// the power limit to 80. When the receiver holds out_word.ready low the output
// register keeps its word, the back pipeline freezes, and the queue fills;
// the front keeps taking commands until the queue and front register are full.
module omni_drive_wheel_mixer_unit #(
  parameter int unsigned QUEUE_DEPTH = odwm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  odwm_cmd_if.sink   in_word,
  odwm_drv_if.source out_word
);

  logic [6:0] power_limit_r, power_limit_nxt;

  // Front to queue.
  logic                 fq_valid, fq_ready;
  odwm_pkg::odwm_item_t fq_item;

  // Queue to back.
  logic                 qb_valid, qb_ready;
  odwm_pkg::odwm_item_t qb_item;

  assign power_limit_nxt = cfg_we ? cfg_wdata : power_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_limit_r <= odwm_pkg::LIMIT_RESET;
    end else begin
      power_limit_r <= power_limit_nxt;
    end
  end

  odwm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .power_limit (power_limit_r),
    .in_word     (in_word),
    .item_valid  (fq_valid),
    .item        (fq_item),
    .item_ready  (fq_ready)
  );

  odwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_item  (fq_item),
    .wr_ready (fq_ready),
    .rd_valid (qb_valid),
    .rd_item  (qb_item),
    .rd_ready (qb_ready)
  );

  odwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (qb_valid),
    .item       (qb_item),
    .item_ready (qb_ready),
    .out_word   (out_word)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the omni drive wheel mixer: directed and random commands.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import odwm_pkg::*;

  // Fixed-point scale and wheel geometry of the mixer, Q2.14 and Q3.14.
  localparam int Q_SCALE      = 16384;
  localparam int SIN15_Q      = 4240;
  localparam int COS15_Q      = 15826;
  localparam int SPIN_GAIN_Q  = 57648;
  localparam int LEVEL_LIMIT  = 100;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RESET_CYCLES = 12;

  // Quarter-wave sine in whole degrees, Q2.14, rounded to nearest.
  localparam int SINE_TABLE [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // One drive command as it is placed on the input channel.
  typedef struct packed {
    logic signed [7:0] power;
    logic [8:0]        heading;
    logic signed [7:0] spin;
    logic signed [7:0] kick;
  } cmd_word_t;

  // One motor driver word; index 0 is channel one, index 3 channel four.
  typedef odwm_chan_t [3:0] drive_word_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  odwm_cmd_if cmd_bus ();
  odwm_drv_if drv_bus ();

  omni_drive_wheel_mixer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (cmd_bus),
    .out_word  (drv_bus)
  );

  // The testbench's own copy of the power limit register.
  logic [6:0]  power_limit;
  drive_word_t expected_drive [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          stall_left     = 0;
  bit          idling_enable  = 1'b1;
  bit          stall_enable   = 1'b1;

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic cmd_word_t make_cmd(input int power, input int heading,
                                         input int spin, input int kick);
    cmd_word_t c;
    c.power   = 8'(power);
    c.heading = 9'(heading);
    c.spin    = 8'(spin);
    c.kick    = 8'(kick);
    return c;
  endfunction

  // Sine of d whole degrees, d in 0..359, folded onto the quarter table.
  function automatic int deg_sine(input int d);
    if (d <= 90) return SINE_TABLE[d];
    if (d <= 180) return SINE_TABLE[180 - d];
    if (d <= 270) return -SINE_TABLE[d - 180];
    return -SINE_TABLE[360 - d];
  endfunction

  // Signed channel value to direction and magnitude; out of range is forward, zero.
  function automatic odwm_chan_t to_channel(input int v);
    odwm_chan_t r;
    r = '0;
    if (v >= -LEVEL_LIMIT && v < 0) begin
      r.reverse = 1'b1;
      r.level   = 7'(-v);
    end else if (v >= 0 && v <= LEVEL_LIMIT) begin
      r.level = 7'(v);
    end
    return r;
  endfunction

  // Clamp, resolve into vx/vy, mix into the three wheels and encode all four channels.
  // Integer division in SystemVerilog truncates toward zero, as the mixer does.
  function automatic drive_word_t predict_drive(input cmd_word_t c);
    int          lim, p, h, sp, s, co, vx, vy, right, back, left;
    drive_word_t w;
    lim = int'(power_limit);
    p   = c.power;
    sp  = c.spin;
    h   = int'(c.heading) % 360;
    if (p > lim) p = lim;
    else if (p < -lim) p = -lim;
    s     = deg_sine(h);
    co    = deg_sine((h + 90) % 360);
    vx    = (p * co) / Q_SCALE;
    vy    = (p * s) / Q_SCALE;
    right = (vx * SIN15_Q - vy * COS15_Q - sp * SPIN_GAIN_Q) / Q_SCALE;
    back  = (vx * Q_SCALE + sp * SPIN_GAIN_Q) / Q_SCALE;
    left  = (-vx * SIN15_Q - vy * COS15_Q + sp * SPIN_GAIN_Q) / Q_SCALE;
    w[0]  = to_channel(-right);
    w[1]  = to_channel(-back);
    w[2]  = to_channel(left);
    w[3]  = to_channel(int'(c.kick));
    return w;
  endfunction

  // Receiver side: ready drops at random while stalls are on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      drv_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 4) == 0) begin
      drv_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 2);
    end else begin
      drv_bus.ready <= 1'b1;
    end
  end

  // Scoreboard. The output word is checked before the input word of the same edge
  // is recorded; registers lie between the two, so they can never be the same item.
  always @(posedge clk) begin
    drive_word_t seen, want;
    if (rst_n) begin
      if (drv_bus.valid && drv_bus.ready) begin
        seen = {drv_bus.ch4_reverse, drv_bus.ch4_level, drv_bus.ch3_reverse,
                drv_bus.ch3_level, drv_bus.ch2_reverse, drv_bus.ch2_level,
                drv_bus.ch1_reverse, drv_bus.ch1_level};
        if (expected_drive.size() == 0) begin
          report_mismatch("output word with no command pending");
        end else begin
          want = expected_drive.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (seen[k].reverse !== want[k].reverse)
              report_mismatch($sformatf("ch%0d_reverse got %0b expected %0b",
                                        k + 1, seen[k].reverse, want[k].reverse));
            if (seen[k].level !== want[k].level)
              report_mismatch($sformatf("ch%0d_level got %0d expected %0d",
                                        k + 1, seen[k].level, want[k].level));
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready)
        expected_drive.push_back(predict_drive(make_cmd(cmd_bus.power, cmd_bus.heading,
                                                        cmd_bus.spin, cmd_bus.kick)));
    end
  end

  // Offers one command word and returns at the edge where it is taken. Valid stays
  // high afterwards, so back-to-back calls stream one word per cycle unless stalled.
  task automatic send_command(input cmd_word_t c);
    @(negedge clk);
    if (idling_enable && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.power   <= c.power;
    cmd_bus.heading <= c.heading;
    cmd_bus.spin    <= c.spin;
    cmd_bus.kick    <= c.kick;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Drops valid and waits until every expected word is out and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_power_limit(input logic [6:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    power_limit = value;
  endtask

  // Random command. Small spin and in-range kick dominate so that the wheel sums
  // mostly stay inside the level range; the rest exercises saturation to zero.
  function automatic cmd_word_t random_command();
    int p, h, sp, k;
    p  = int'($urandom_range(0, 255)) - 128;
    h  = ($urandom_range(0, 6) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    sp = ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, 60)) - 30
                                     : int'($urandom_range(0, 255)) - 128;
    k  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 200)) - 100
                                     : int'($urandom_range(0, 255)) - 128;
    return make_cmd(p, h, sp, k);
  endfunction

  // Reset limit of 80: power clamp on both signs, quadrant headings, headings that
  // wrap past 359, spin saturating the wheels, and kick around every level edge.
  task automatic test_directed_reset_limit();
    send_command(make_cmd(127, 0, 0, 0));
    send_command(make_cmd(-128, 90, 0, 0));
    send_command(make_cmd(100, 180, 0, -128));
    send_command(make_cmd(80, 270, 0, 127));
    send_command(make_cmd(-80, 359, 0, -100));
    send_command(make_cmd(50, 360, 0, 100));
    send_command(make_cmd(50, 511, 0, -1));
    send_command(make_cmd(0, 0, 127, 101));
    send_command(make_cmd(0, 0, -128, -101));
    send_command(make_cmd(0, 45, 28, 0));
    send_command(make_cmd(0, 45, -28, 0));
    send_command(make_cmd(0, 0, 29, 0));
    send_command(make_cmd(127, 135, -10, 1));
    send_command(make_cmd(-1, 225, 1, 0));
    send_command(make_cmd(1, 315, -1, 0));
    send_command(make_cmd(-79, 450, 3, -99));
  endtask

  // Limit of zero kills all translation; 127 lets full power through; 100 reaches
  // the exact edge of the level range on the back wheel.
  task automatic test_limit_extremes();
    write_power_limit(7'd0);
    send_command(make_cmd(127, 30, 5, 50));
    send_command(make_cmd(-128, 200, -5, -50));
    write_power_limit(7'd127);
    send_command(make_cmd(127, 0, 0, 0));
    send_command(make_cmd(-128, 90, 0, 0));
    send_command(make_cmd(127, 60, 20, 0));
    write_power_limit(7'd100);
    send_command(make_cmd(127, 0, 0, 0));
    send_command(make_cmd(-128, 0, 0, 0));
  endtask

  // Several limit settings, each with a batch of random commands under random idling.
  task automatic test_random_limits();
    logic [6:0] limits [6];
    limits = '{7'($urandom_range(0, 127)), 7'd100, 7'd0, 7'd127,
               7'($urandom_range(0, 100)), 7'd1};
    foreach (limits[i]) begin
      write_power_limit(limits[i]);
      repeat (95) send_command(random_command());
    end
  endtask

  // Last stretch: no idling on either side, one word per cycle.
  task automatic test_back_to_back();
    write_power_limit(7'($urandom_range(0, 127)));
    idling_enable = 1'b0;
    stall_enable  = 1'b0;
    repeat (100) send_command(random_command());
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    cmd_bus.valid   = 1'b0;
    cmd_bus.power   = '0;
    cmd_bus.heading = '0;
    cmd_bus.spin    = '0;
    cmd_bus.kick    = '0;
    drv_bus.ready   = 1'b1;
    power_limit     = LIMIT_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_reset_limit();
    test_limit_extremes();
    test_random_limits();
    test_back_to_back();

    wait_idle();
    if (expected_drive.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_drive.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: omni_drive_wheel_mixer_unit.f
rtl/odwm_pkg.sv
rtl/odwm_cmd_if.sv
rtl/odwm_drv_if.sv
rtl/odwm_front.sv
rtl/odwm_queue.sv
rtl/odwm_back.sv
rtl/omni_drive_wheel_mixer_unit.sv
tb/sv/testbench.sv
